// ===== sv/rne_pkg.sv =====
package rne_pkg;

    localparam int unsigned NumberWidth = 12;
    localparam int unsigned LetterWidth = 7;
    localparam int unsigned DigitCount  = 4;
    localparam int unsigned LenWidth    = 3;
    localparam logic [NumberWidth-1:0] NumberMax = 12'd3999;

    localparam logic [LetterWidth-1:0] LetterI    = 7'h49;
    localparam logic [LetterWidth-1:0] LetterV    = 7'h56;
    localparam logic [LetterWidth-1:0] LetterX    = 7'h58;
    localparam logic [LetterWidth-1:0] LetterL    = 7'h4C;
    localparam logic [LetterWidth-1:0] LetterC    = 7'h43;
    localparam logic [LetterWidth-1:0] LetterD    = 7'h44;
    localparam logic [LetterWidth-1:0] LetterM    = 7'h4D;
    localparam logic [LetterWidth-1:0] LetterNone = 7'h00;

    // Digit positions, most significant first.
    localparam logic [1:0] PosThousands = 2'd0;
    localparam logic [1:0] PosHundreds  = 2'd1;
    localparam logic [1:0] PosTens      = 2'd2;
    localparam logic [1:0] PosUnits     = 2'd3;

    typedef enum logic [1:0] {
        SYM_ONE  = 2'd0,
        SYM_FIVE = 2'd1,
        SYM_TEN  = 2'd2
    } sym_t;

    typedef struct packed {
        logic             range_error;
        logic             additive;
        logic [3:0][3:0]  digits;
    } entry_t;

    function automatic logic [LenWidth-1:0] digit_len(input logic [3:0] d, input logic add);
        logic [LenWidth-1:0] len;
        case (d)
            4'd1:    len = 3'd1;
            4'd2:    len = 3'd2;
            4'd3:    len = 3'd3;
            4'd4:    len = add ? 3'd4 : 3'd2;
            4'd5:    len = 3'd1;
            4'd6:    len = 3'd2;
            4'd7:    len = 3'd3;
            4'd8:    len = 3'd4;
            4'd9:    len = add ? 3'd5 : 3'd2;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic sym_t digit_sym(input logic [3:0] d, input logic add,
                                       input logic [LenWidth-1:0] k);
        sym_t sym;
        if (d == 4'd4) begin
            sym = (add || k == 3'd0) ? SYM_ONE : SYM_FIVE;
        end else if (d == 4'd9) begin
            if (add) begin
                sym = (k == 3'd0) ? SYM_FIVE : SYM_ONE;
            end else begin
                sym = (k == 3'd0) ? SYM_ONE : SYM_TEN;
            end
        end else if (d >= 4'd5) begin
            sym = (k == 3'd0) ? SYM_FIVE : SYM_ONE;
        end else begin
            sym = SYM_ONE;
        end
        return sym;
    endfunction

    function automatic logic [LetterWidth-1:0] roman_letter(input logic [1:0] pos, input sym_t sym);
        logic [LetterWidth-1:0] ch;
        case (pos)
            PosHundreds: begin
                case (sym)
                    SYM_FIVE: ch = LetterD;
                    SYM_TEN:  ch = LetterM;
                    default:  ch = LetterC;
                endcase
            end
            PosTens: begin
                case (sym)
                    SYM_FIVE: ch = LetterL;
                    SYM_TEN:  ch = LetterC;
                    default:  ch = LetterX;
                endcase
            end
            PosUnits: begin
                case (sym)
                    SYM_FIVE: ch = LetterV;
                    SYM_TEN:  ch = LetterX;
                    default:  ch = LetterI;
                endcase
            end
            default: ch = LetterM;
        endcase
        return ch;
    endfunction

endpackage

// ===== sv/rne_front.sv =====
module rne_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [11:0]                  number,
    input  logic                         additive_form,
    output logic                         push_valid,
    input  logic                         push_ready,
    output rne_pkg::entry_t              push_data
);
    import rne_pkg::*;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_HUND = 4'b0010,
        F_TENS = 4'b0100,
        F_PUSH = 4'b1000
    } front_state_t;

    front_state_t state_reg, state_next;
    entry_t       entry_reg, entry_next;
    logic [9:0]   rem_reg, rem_next;

    logic [2:0]   ge_th;
    logic [1:0]   th;
    logic [8:0]   ge_dec;
    logic [3:0]   dec;
    logic [9:0]   scale;
    logic         bad;

    assign in_ready   = (state_reg == F_IDLE);
    assign push_valid = (state_reg == F_PUSH);
    assign push_data  = entry_reg;

    always_comb
    begin
        bad   = (number == '0) || (number > NumberMax);
        ge_th = {number >= 12'd3000, number >= 12'd2000, number >= 12'd1000};
        th    = 2'($countones(ge_th));
        scale = (state_reg == F_HUND) ? 10'd100 : 10'd10;
        for (int k = 0; k < 9; k++)
        begin
            ge_dec[k] = rem_reg >= 10'((k + 1) * ((state_reg == F_HUND) ? 100 : 10));
        end
        dec = 4'($countones(ge_dec));
    end

    always_comb
    begin
        state_next = state_reg;
        entry_next = entry_reg;
        rem_next   = rem_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    entry_next.range_error = bad;
                    entry_next.additive    = additive_form;
                    entry_next.digits      = '0;
                    if (bad)
                    begin
                        state_next = F_PUSH;
                    end
                    else
                    begin
                        entry_next.digits[PosThousands] = {2'b00, th};
                        case (th)
                            2'd1:    rem_next = 10'(number - 12'd1000);
                            2'd2:    rem_next = 10'(number - 12'd2000);
                            2'd3:    rem_next = 10'(number - 12'd3000);
                            default: rem_next = number[9:0];
                        endcase
                        state_next = F_HUND;
                    end
                end
            end
            F_HUND:
            begin
                entry_next.digits[PosHundreds] = dec;
                rem_next   = rem_reg - 10'(dec * scale);
                state_next = F_TENS;
            end
            F_TENS:
            begin
                entry_next.digits[PosTens]  = dec;
                entry_next.digits[PosUnits] = 4'(rem_reg - 10'(dec * scale));
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        rem_reg   <= rem_next;
    end

endmodule

// ===== sv/rne_queue.sv =====
module rne_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  rne_pkg::entry_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output rne_pkg::entry_t pop_data
);
    import rne_pkg::*;

    localparam int unsigned PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CountWidth = $clog2(DEPTH + 1);

    entry_t                slots_reg [DEPTH];
    logic [PtrWidth-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrWidth-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CountWidth-1:0] count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    assign push_ready = (count_reg != CountWidth'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/rne_back.sv =====
module rne_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  rne_pkg::entry_t pop_data,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [6:0]      letter,
    output logic            last,
    output logic            range_error
);
    import rne_pkg::*;

    entry_t                  entry_reg;
    logic                    busy_reg, busy_next;
    logic [1:0]              pos_reg, pos_next;
    logic [LenWidth-1:0]     idx_reg, idx_next;
    logic                    out_valid_reg, out_valid_next;
    logic [LetterWidth-1:0]  letter_reg, letter_next;
    logic                    last_reg, last_next;
    logic                    err_reg, err_next;

    logic [LenWidth-1:0]     lens [DigitCount];
    logic [LenWidth-1:0]     cur_len;
    logic                    later;
    logic [1:0]              after_pos;
    logic [1:0]              first_pos;
    logic                    emit;
    logic                    final_letter;
    logic                    load;

    assign out_valid   = out_valid_reg;
    assign letter      = letter_reg;
    assign last        = last_reg;
    assign range_error = err_reg;
    assign pop_ready   = !busy_reg;
    assign load        = pop_valid && !busy_reg;
    assign emit        = busy_reg && (!out_valid_reg || out_ready);

    always_comb
    begin
        for (int p = 0; p < DigitCount; p++)
        begin
            lens[p] = digit_len(entry_reg.digits[p], entry_reg.additive);
        end
        cur_len   = lens[pos_reg];
        later     = 1'b0;
        after_pos = pos_reg;
        first_pos = PosUnits;
        for (int q = DigitCount - 1; q >= 0; q--)
        begin
            if (2'(q) > pos_reg && lens[q] != '0)
            begin
                later     = 1'b1;
                after_pos = 2'(q);
            end
            if (digit_len(pop_data.digits[q], pop_data.additive) != '0)
            begin
                first_pos = 2'(q);
            end
        end
        final_letter = entry_reg.range_error || ((idx_reg == cur_len - 1'b1) && !later);
    end

    always_comb
    begin
        busy_next      = busy_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        letter_next    = letter_reg;
        last_next      = last_reg;
        err_next       = err_reg;
        if (load)
        begin
            busy_next = 1'b1;
            pos_next  = first_pos;
            idx_next  = '0;
        end
        else if (emit)
        begin
            out_valid_next = 1'b1;
            last_next      = final_letter;
            err_next       = entry_reg.range_error;
            if (entry_reg.range_error)
            begin
                letter_next = LetterNone;
            end
            else
            begin
                letter_next = roman_letter(pos_reg,
                    digit_sym(entry_reg.digits[pos_reg], entry_reg.additive, idx_reg));
            end
            if (final_letter)
            begin
                busy_next = 1'b0;
            end
            else if (idx_reg == cur_len - 1'b1)
            begin
                pos_next = after_pos;
                idx_next = '0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            entry_reg <= pop_data;
        end
        pos_reg    <= pos_next;
        idx_reg    <= idx_next;
        letter_reg <= letter_next;
        last_reg   <= last_next;
        err_reg    <= err_next;
    end

endmodule

// ===== sv/roman_numeral_encoder_unit.sv =====
// Roman numeral encoder.
// The input channel (in_valid, in_ready, number, additive_form) takes one
// integer per item; the output channel (out_valid, out_ready, letter, last,
// range_error) returns its numeral one ASCII letter per item, most
// significant digit first, with last set on the final letter.
// A number outside 1 to 3999 gives a single item with letter 0, last and
// range_error set.
// The front splits the number into decimal digits, thousands on acceptance,
// then hundreds, then tens and units, and places it in a queue of
// QUEUE_DEPTH entries; it takes no new number until it has pushed the last
// one, and it waits while the queue is full.
// The back loads a queue entry and then emits one letter per cycle while the
// receiver does not stall; a numeral has at most 18 letters, for 3999 in
// additive form.
// Reset empties the queue and drops any item in progress.
// When the receiver stalls, the output register holds its letter, the back
// waits, and the queue absorbs further numbers until full, then in_ready
// falls.
module roman_numeral_encoder_unit #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [11:0] number,
    input  logic        additive_form,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [6:0]  letter,
    output logic        last,
    output logic        range_error
);
    import rne_pkg::*;

    logic   push_valid;
    logic   push_ready;
    entry_t push_data;
    logic   pop_valid;
    logic   pop_ready;
    entry_t pop_data;

    rne_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .number        (number),
        .additive_form (additive_form),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_data     (push_data)
    );

    rne_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    rne_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .letter      (letter),
        .last        (last),
        .range_error (range_error)
    );

endmodule

// ===== sv/rne_checker.sv =====
module rne_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [11:0] number,
    input logic        additive_form,
    input logic        out_valid,
    input logic        out_ready,
    input logic [6:0]  letter,
    input logic        last,
    input logic        range_error
);
    import rne_pkg::*;

    // A held result item must not change while the receiver stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(letter) && $stable(last)
            && $stable(range_error))
    else $error("output item changed while stalled");

    // An error item is a single item with no letter.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_error |-> last && letter == LetterNone)
    else $error("malformed error item");

    // Every ordinary item carries one of the seven numeral letters.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !range_error |-> letter == LetterI || letter == LetterV
            || letter == LetterX || letter == LetterL || letter == LetterC
            || letter == LetterD || letter == LetterM)
    else $error("letter outside the numeral alphabet");

    // The front is busy in the cycle after it takes a number.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("front accepted on consecutive cycles");

endmodule

bind roman_numeral_encoder_unit rne_checker u_rne_checker (.*);

// ===== verif/roman_numeral_encoder_unit_tb.sv =====
`timescale 1ns / 100ps

module roman_numeral_encoder_unit_tb;

    import rne_pkg::*;

    localparam int QuietLimit = 2000;
    localparam int DrillRows  = 24;
    localparam int LongHold   = 150;

    typedef struct packed {
        logic [LetterWidth-1:0] letter;
        logic                   last;
        logic                   range_error;
    } glyph_t;

    typedef enum logic [1:0] {
        BY_MODEL,
        SPELLED,
        OUT_OF_RANGE
    } row_check_t;

    typedef struct packed {
        logic [NumberWidth-1:0] value;
        logic                   additive;
        row_check_t             check;
        logic [143:0]           spelled;
    } drill_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [NumberWidth-1:0] number;
    logic                   additive_form;
    logic                   out_valid;
    logic                   out_ready;
    logic [LetterWidth-1:0] letter;
    logic                   last;
    logic                   range_error;

    glyph_t                 letters_due[$];
    logic [LetterWidth-1:0] numeral_run[$];
    row_check_t             offered_check;
    logic [143:0]           offered_spelled;
    int                     send_idle_pct;
    int                     recv_idle_pct;
    int                     stall_budget;
    int                     quiet_cycles;
    int                     mismatch_count;

    drill_row_t drill [DrillRows] = '{
        '{12'd0,    1'b0, OUT_OF_RANGE, 144'd0},
        '{12'd4095, 1'b1, OUT_OF_RANGE, 144'd0},
        '{12'd4000, 1'b0, OUT_OF_RANGE, 144'd0},
        '{12'd4000, 1'b1, OUT_OF_RANGE, 144'd0},
        '{12'd3999, 1'b0, SPELLED,      "MMMCMXCIX"},
        '{12'd3999, 1'b1, SPELLED,      "MMMDCCCCLXXXXVIIII"},
        '{12'd1,    1'b0, SPELLED,      "I"},
        '{12'd1,    1'b1, SPELLED,      "I"},
        '{12'd4,    1'b0, SPELLED,      "IV"},
        '{12'd4,    1'b1, SPELLED,      "IIII"},
        '{12'd9,    1'b0, SPELLED,      "IX"},
        '{12'd9,    1'b1, SPELLED,      "VIIII"},
        '{12'd3000, 1'b0, SPELLED,      "MMM"},
        '{12'd40,   1'b0, BY_MODEL,     144'd0},
        '{12'd40,   1'b1, BY_MODEL,     144'd0},
        '{12'd90,   1'b0, BY_MODEL,     144'd0},
        '{12'd90,   1'b1, BY_MODEL,     144'd0},
        '{12'd400,  1'b0, BY_MODEL,     144'd0},
        '{12'd900,  1'b1, BY_MODEL,     144'd0},
        '{12'd444,  1'b1, BY_MODEL,     144'd0},
        '{12'd2048, 1'b1, BY_MODEL,     144'd0},
        '{12'd1365, 1'b0, BY_MODEL,     144'd0},
        '{12'd2730, 1'b1, BY_MODEL,     144'd0},
        '{12'd3888, 1'b1, BY_MODEL,     144'd0}
    };

    roman_numeral_encoder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .number        (number),
        .additive_form (additive_form),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .letter        (letter),
        .last          (last),
        .range_error   (range_error)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic void commit_numeral();
        glyph_t g;
        int     i;
        for (i = 0; i < numeral_run.size(); i++)
        begin
            g.letter      = numeral_run[i];
            g.last        = (i == numeral_run.size() - 1);
            g.range_error = 1'b0;
            letters_due.push_back(g);
        end
        numeral_run.delete();
    endfunction

    function automatic void append_decade(input int unsigned d, input logic add,
                                          input logic [LetterWidth-1:0] one,
                                          input logic [LetterWidth-1:0] five,
                                          input logic [LetterWidth-1:0] ten);
        if (d == 4)
        begin
            if (add)
            begin
                repeat (4) numeral_run.push_back(one);
            end
            else
            begin
                numeral_run.push_back(one);
                numeral_run.push_back(five);
            end
        end
        else if (d == 9)
        begin
            if (add)
            begin
                numeral_run.push_back(five);
                repeat (4) numeral_run.push_back(one);
            end
            else
            begin
                numeral_run.push_back(one);
                numeral_run.push_back(ten);
            end
        end
        else
        begin
            if (d >= 5)
            begin
                numeral_run.push_back(five);
            end
            repeat (d % 5) numeral_run.push_back(one);
        end
    endfunction

    function automatic void predict_numeral(input logic [NumberWidth-1:0] n, input logic add);
        int unsigned v;
        glyph_t      g;
        v = n;
        if (v < 1 || v > NumberMax)
        begin
            g.letter      = LetterNone;
            g.last        = 1'b1;
            g.range_error = 1'b1;
            letters_due.push_back(g);
        end
        else
        begin
            repeat (v / 1000) numeral_run.push_back(LetterM);
            append_decade((v / 100) % 10, add, LetterC, LetterD, LetterM);
            append_decade((v / 10) % 10, add, LetterX, LetterL, LetterC);
            append_decade(v % 10, add, LetterI, LetterV, LetterX);
            commit_numeral();
        end
    endfunction

    function automatic void expect_spelled(input logic [143:0] text);
        int         i;
        logic [7:0] c;
        for (i = 17; i >= 0; i--)
        begin
            c = text[i*8 +: 8];
            if (c != 8'd0)
            begin
                numeral_run.push_back(c[LetterWidth-1:0]);
            end
        end
        commit_numeral();
    endfunction

    function automatic void note_mismatch(input string what, input glyph_t want);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%s: expected letter %h last %b range_error %b, %s %h last %b range_error %b",
                     what, want.letter, want.last, want.range_error, "got letter",
                     letter, last, range_error);
        end
    endfunction

    always @(posedge clk)
    begin
        glyph_t want;
        glyph_t error_glyph;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                case (offered_check)
                    SPELLED:
                    begin
                        expect_spelled(offered_spelled);
                    end
                    OUT_OF_RANGE:
                    begin
                        error_glyph.letter      = LetterNone;
                        error_glyph.last        = 1'b1;
                        error_glyph.range_error = 1'b1;
                        letters_due.push_back(error_glyph);
                    end
                    default:
                    begin
                        predict_numeral(number, additive_form);
                    end
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (letters_due.size() == 0)
                begin
                    want = '0;
                    note_mismatch("Unexpected item", want);
                end
                else
                begin
                    want = letters_due.pop_front();
                    if (letter !== want.letter || last !== want.last
                        || range_error !== want.range_error)
                    begin
                        note_mismatch("Item mismatch", want);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= QuietLimit)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_budget > 0)
            begin
                out_ready    <= 1'b0;
                stall_budget = stall_budget - 1;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic offer_number(input logic [NumberWidth-1:0] n, input logic add,
                                input row_check_t check, input logic [143:0] text);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        offered_check   = check;
        offered_spelled = text;
        in_valid      <= 1'b1;
        number        <= n;
        additive_form <= add;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic offer_random(input int count);
        logic [NumberWidth-1:0] n;
        repeat (count)
        begin
            case ($urandom_range(9))
                0:       n = $urandom_range(1) ? 12'd0 : 12'($urandom_range(4095, 4000));
                1:       n = 12'($urandom_range(9, 1));
                default: n = 12'($urandom_range(3999, 1));
            endcase
            offer_number(n, 1'($urandom_range(1)), BY_MODEL, 144'd0);
        end
    endtask

    task automatic drain_numerals();
        @(negedge clk);
        in_valid <= 1'b0;
        while (letters_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        int i;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        number          = '0;
        additive_form   = 1'b0;
        offered_check   = BY_MODEL;
        offered_spelled = '0;
        stall_budget    = 0;
        quiet_cycles    = 0;
        mismatch_count  = 0;
        send_idle_pct   = 24;
        recv_idle_pct   = 62;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DrillRows; i++)
        begin
            offer_number(drill[i].value, drill[i].additive, drill[i].check, drill[i].spelled);
        end
        offer_random(60);
        drain_numerals();

        send_idle_pct = 62;
        recv_idle_pct = 24;
        offer_random(60);
        drain_numerals();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_budget  = LongHold;
        offer_random(70);
        drain_numerals();

        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && letters_due.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
